>>> design/dmfp_pkg.sv
// ----------------------------------------------------------------------------
// dmfp_pkg
// Types and constants shared by the DNS message field parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dmfp_pkg;

    typedef enum logic [3:0] {
        PH_HEADER = 4'd0,
        PH_NAME   = 4'd1,
        PH_LABEL  = 4'd2,
        PH_PTR    = 4'd3,
        PH_TYPE   = 4'd4,
        PH_CLASS  = 4'd5,
        PH_TTL    = 4'd6,
        PH_RDLEN  = 4'd7,
        PH_RDATA  = 4'd8,
        PH_DONE   = 4'd9,
        PH_SKIP   = 4'd10
    } t_phase;

    localparam logic [4:0] K_ID      = 5'd0;
    localparam logic [4:0] K_QR      = 5'd1;
    localparam logic [4:0] K_OPCODE  = 5'd2;
    localparam logic [4:0] K_AA      = 5'd3;
    localparam logic [4:0] K_TC      = 5'd4;
    localparam logic [4:0] K_RD      = 5'd5;
    localparam logic [4:0] K_RA      = 5'd6;
    localparam logic [4:0] K_Z       = 5'd7;
    localparam logic [4:0] K_RCODE   = 5'd8;
    localparam logic [4:0] K_QDCOUNT = 5'd9;
    localparam logic [4:0] K_LABLEN  = 5'd13;
    localparam logic [4:0] K_LABCHR  = 5'd14;
    localparam logic [4:0] K_NAMEEND = 5'd15;
    localparam logic [4:0] K_PTR     = 5'd16;
    localparam logic [4:0] K_TYPE    = 5'd17;
    localparam logic [4:0] K_CLASS   = 5'd18;
    localparam logic [4:0] K_TTL     = 5'd19;
    localparam logic [4:0] K_RDLEN   = 5'd20;
    localparam logic [4:0] K_RDATA   = 5'd21;
    localparam logic [4:0] K_MSGEND  = 5'd22;

    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_TRUNC    = 3'd1;
    localparam logic [2:0] E_RESERVED = 3'd2;
    localparam logic [2:0] E_TRAILING = 3'd3;
    localparam logic [2:0] E_TOOLONG  = 3'd4;

    localparam logic [2:0] SEC_HEADER   = 3'd0;
    localparam logic [2:0] SEC_QUESTION = 3'd1;

    localparam int MaxRes = 5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in;

    typedef struct packed {
        logic [2:0]  section;
        logic [4:0]  field_kind;
        logic [31:0] field_value;
        logic [15:0] record_index;
        logic [2:0]  error_code;
        logic        last_of_run;
    } t_out;

    // a batch of results caused by one byte
    typedef struct packed {
        logic [2:0]  n;
        t_out [MaxRes-1:0] res;
    } t_batch;

endpackage

`default_nettype wire

>>> design/dns_message_field_parser.sv
// ----------------------------------------------------------------------------
// dns_message_field_parser
// Byte-wide DNS message parser emitting tagged header, question and record
// fields.
// ----------------------------------------------------------------------------
//  channel | signals                       | payload
//  in      | i_in_valid / o_in_ready       | t_in  (data_byte, end_of_message)
//  out     | o_out_valid / i_out_ready     | t_out (one field per beat)
//
//  One byte accepted per cycle while the 16-entry result queue has room
//  for five results; a byte's results are written at its accepting edge
//  and the first can leave in the following cycle.
//  Results leave one per beat, so bytes with several results throttle input.
//  Synchronous active-low reset returns the parser to the header phase.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_message_field_parser import dmfp_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out
);

    t_batch batch;
    logic   take;

    assign take = i_in_valid && o_in_ready;

    dmfp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (take),
        .i_in    (i_in),
        .o_batch (batch)
    );

    dmfp_outq u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_batch (batch),
        .o_space (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out)
    );

endmodule

`default_nettype wire

>>> design/dmfp_core.sv
// ----------------------------------------------------------------------------
// dmfp_core
// Parse state and per-byte result generation; one byte each enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dmfp_core import dmfp_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    input  wire t_in    i_in,
    output t_batch      o_batch
);

    t_phase      r_ph,   n_ph;
    logic [3:0]  r_cnt,  n_cnt;
    logic [31:0] r_acc,  n_acc;
    logic [2:0]  r_sec,  n_sec;
    logic [15:0] r_left [4];
    logic [15:0] n_left [4];
    logic [15:0] r_rec,  n_rec;
    logic [5:0]  r_lab,  n_lab;
    logic [7:0]  r_nlen, n_nlen;
    logic [15:0] r_rdl,  n_rdl;

    t_batch      b;
    logic [7:0]  d;
    logic [31:0] acc_sh;
    logic [8:0]  total;
    logic [15:0] dec_left;
    logic [2:0]  s_next;
    logic [15:0] rdl_dec;
    logic [1:0]  cnt_idx;

    always_comb begin
        d      = i_in.data_byte;
        acc_sh = {r_acc[23:0], d};
        total  = 9'(r_nlen) + 9'(d) + 9'd1;
        n_ph = r_ph; n_cnt = r_cnt; n_acc = r_acc; n_sec = r_sec;
        n_rec = r_rec; n_lab = r_lab; n_nlen = r_nlen; n_rdl = r_rdl;
        for (int k = 0; k < 4; k++) n_left[k] = r_left[k];
        b = '0;
        dec_left = '0;
        s_next = '0;
        rdl_dec = r_rdl - 16'd1;
        // count bytes 5, 7, 9 and 11 map to count slots 0..3 (sections 1..4)
        cnt_idx = r_cnt[2:1] - 2'd2;

        unique case (r_ph)
            PH_HEADER: begin
                n_acc = acc_sh;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd1) begin
                    b.res[0].field_kind = K_ID; b.res[0].field_value = {16'd0, acc_sh[15:0]};
                    b.n = 3'd1;
                end else if (r_cnt == 4'd2) begin
                    b.res[0].field_kind = K_QR;     b.res[0].field_value = 32'(d[7]);
                    b.res[1].field_kind = K_OPCODE; b.res[1].field_value = 32'(d[6:3]);
                    b.res[2].field_kind = K_AA;     b.res[2].field_value = 32'(d[2]);
                    b.res[3].field_kind = K_TC;     b.res[3].field_value = 32'(d[1]);
                    b.n = 3'd4;
                end else if (r_cnt == 4'd3) begin
                    b.res[0].field_kind = K_RD;    b.res[0].field_value = 32'(r_acc[0]);
                    b.res[1].field_kind = K_RA;    b.res[1].field_value = 32'(d[7]);
                    b.res[2].field_kind = K_Z;     b.res[2].field_value = 32'(d[6:4]);
                    b.res[3].field_kind = K_RCODE; b.res[3].field_value = 32'(d[3:0]);
                    b.n = 3'd4;
                end else if (r_cnt >= 4'd5 && r_cnt[0]) begin
                    n_left[cnt_idx] = acc_sh[15:0];
                    b.res[0].field_kind  = K_QDCOUNT + 5'(cnt_idx);
                    b.res[0].field_value = {16'd0, acc_sh[15:0]};
                    b.n = 3'd1;
                    if (r_cnt == 4'd11) begin
                        n_cnt = '0; n_acc = '0; n_rec = '0; n_nlen = '0;
                        // pick the first non-empty section
                        priority if (n_left[0] != 0) begin
                            n_sec = 3'd1; n_ph = PH_NAME;
                        end else if (n_left[1] != 0) begin
                            n_sec = 3'd2; n_ph = PH_NAME;
                        end else if (n_left[2] != 0) begin
                            n_sec = 3'd3; n_ph = PH_NAME;
                        end else if (n_left[3] != 0) begin
                            n_sec = 3'd4; n_ph = PH_NAME;
                        end else begin
                            n_ph = PH_DONE;
                        end
                    end
                end
            end
            PH_NAME: begin
                b.n = 3'd1;
                b.res[0].field_value = 32'(d);
                b.res[0].field_kind  = K_LABLEN;
                if (d == 8'd0) begin
                    b.res[0].field_kind  = K_NAMEEND;
                    b.res[0].field_value = 32'(r_nlen) + 32'd1;
                    n_ph = PH_TYPE; n_cnt = '0; n_acc = '0;
                end else if (d[7:6] == 2'b11) begin
                    b.n = 3'd0;
                    n_acc = 32'(d[5:0]);
                    n_ph = PH_PTR;
                end else if (d[7:6] != 2'b00) begin
                    b.res[0].error_code = E_RESERVED;
                    n_ph = PH_SKIP;
                end else if (total > 9'd254) begin
                    b.res[0].error_code = E_TOOLONG;
                    n_ph = PH_SKIP;
                end else begin
                    n_nlen = total[7:0];
                    n_lab  = d[5:0];
                    n_ph   = PH_LABEL;
                end
            end
            PH_LABEL: begin
                b.n = 3'd1;
                b.res[0].field_kind = K_LABCHR; b.res[0].field_value = 32'(d);
                n_lab = r_lab - 6'd1;
                if (n_lab == 6'd0) n_ph = PH_NAME;
            end
            PH_PTR: begin
                b.n = 3'd1;
                b.res[0].field_kind  = K_PTR;
                b.res[0].field_value = {18'd0, r_acc[5:0], d};
                n_ph = PH_TYPE; n_cnt = '0; n_acc = '0;
            end
            PH_TYPE, PH_CLASS, PH_TTL, PH_RDLEN: begin
                n_acc = acc_sh;
                n_cnt = r_cnt + 4'd1;
                if ((r_ph == PH_TTL && r_cnt == 4'd3) || (r_ph != PH_TTL && r_cnt == 4'd1)) begin
                    n_cnt = '0; n_acc = '0; b.n = 3'd1;
                    b.res[0].field_value = (r_ph == PH_TTL) ? acc_sh : {16'd0, acc_sh[15:0]};
                    unique case (r_ph)
                        PH_TYPE:  begin b.res[0].field_kind = K_TYPE; n_ph = PH_CLASS; end
                        PH_CLASS: begin
                            b.res[0].field_kind = K_CLASS;
                            n_ph = (r_sec == SEC_QUESTION) ? PH_RDATA : PH_TTL;
                        end
                        PH_TTL:   begin b.res[0].field_kind = K_TTL; n_ph = PH_RDLEN; end
                        default:  begin
                            b.res[0].field_kind = K_RDLEN;
                            n_rdl = acc_sh[15:0];
                            n_ph = PH_RDATA;
                        end
                    endcase
                end
            end
            PH_RDATA: begin
                b.n = 3'd1;
                b.res[0].field_kind = K_RDATA; b.res[0].field_value = 32'(d);
                n_rdl = rdl_dec;
            end
            PH_DONE: begin
                b.n = 3'd1;
                b.res[0].field_kind = K_MSGEND; b.res[0].field_value = 32'(d);
                b.res[0].error_code = E_TRAILING;
                n_ph = PH_SKIP;
            end
            default: n_ph = PH_SKIP;
        endcase

        // record finish: question class done, zero rdlength, last rdata byte
        if ((r_ph == PH_CLASS && r_cnt == 4'd1 && r_sec == SEC_QUESTION) ||
            (r_ph == PH_RDLEN && r_cnt == 4'd1 && acc_sh[15:0] == 16'd0) ||
            (r_ph == PH_RDATA && rdl_dec == 16'd0)) begin
            dec_left = r_left[2'(r_sec - 3'd1)] - 16'd1;
            n_left[2'(r_sec - 3'd1)] = dec_left;
            n_rec = r_rec + 16'd1;
            n_nlen = '0; n_cnt = '0; n_acc = '0;
            if (dec_left != 16'd0) begin
                n_ph = PH_NAME;
            end else begin
                n_rec = '0;
                n_ph = PH_DONE;
                for (int s = 4; s >= 2; s--) begin
                    if (3'(s) > r_sec && n_left[s-1] != 16'd0) s_next = 3'(s);
                end
                if (s_next != 3'd0) begin
                    n_sec = s_next; n_ph = PH_NAME;
                end
            end
        end

        for (int k = 0; k < MaxRes; k++) begin
            b.res[k].section      = r_sec;
            b.res[k].record_index = (r_sec == SEC_HEADER) ? 16'd0 : r_rec;
        end

        if (i_in.end_of_message) begin
            b.res[b.n].section      = n_sec;
            b.res[b.n].field_kind   = K_MSGEND;
            b.res[b.n].field_value  = '0;
            b.res[b.n].record_index = '0;
            b.res[b.n].error_code   = (n_ph == PH_DONE || n_ph == PH_SKIP) ? E_NONE : E_TRUNC;
            b.n = b.n + 3'd1;
            n_ph = PH_HEADER; n_cnt = '0; n_acc = '0; n_sec = SEC_HEADER;
            n_rec = '0; n_lab = '0; n_nlen = '0; n_rdl = '0;
            for (int k = 0; k < 4; k++) n_left[k] = '0;
        end
        if (b.n != 3'd0) b.res[b.n - 3'd1].last_of_run = 1'b1;
        o_batch = b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_HEADER; r_cnt <= '0; r_acc <= '0; r_sec <= SEC_HEADER;
            r_rec <= '0; r_lab <= '0; r_nlen <= '0; r_rdl <= '0;
            for (int k = 0; k < 4; k++) r_left[k] <= '0;
        end else if (i_en) begin
            r_ph <= n_ph; r_cnt <= n_cnt; r_acc <= n_acc; r_sec <= n_sec;
            r_rec <= n_rec; r_lab <= n_lab; r_nlen <= n_nlen; r_rdl <= n_rdl;
            for (int k = 0; k < 4; k++) r_left[k] <= n_left[k];
        end
    end

endmodule

`default_nettype wire

>>> design/dmfp_outq.sv
// ----------------------------------------------------------------------------
// dmfp_outq
// Result queue: takes a batch of up to five results, drains one per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module dmfp_outq import dmfp_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_batch i_batch,
    output logic        o_space,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_out        o_data
);

    localparam int Depth = 16;

    t_out        r_mem [Depth];
    logic [3:0]  r_wp, r_rp;
    logic [4:0]  r_fill;
    logic        pop;
    logic [2:0]  push_n;

    assign push_n  = i_push ? i_batch.n : 3'd0;
    assign pop     = o_valid && i_ready;
    assign o_valid = r_fill != 5'd0;
    assign o_data  = r_mem[r_rp];
    // room for a full batch even without a pop this beat
    assign o_space = r_fill <= 5'(Depth - MaxRes);

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MaxRes; k++) begin
            if (3'(k) < push_n) r_mem[r_wp + 4'(k)] <= i_batch.res[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_fill <= '0;
        end else begin
            r_wp   <= r_wp + 4'(push_n);
            r_rp   <= r_rp + 4'(pop);
            r_fill <= r_fill + 5'(push_n) - 5'(pop);
        end
    end

endmodule

`default_nettype wire

>>> design/dmfp_checker.sv
// ----------------------------------------------------------------------------
// dmfp_port_checker
// Port-level checks on the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module dmfp_port_checker import dmfp_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_in_ready,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire t_out o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.field_kind <= K_MSGEND && o_out.section <= 3'd4)
        else $error("bad kind or section");

    a_hdr_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.section == SEC_HEADER || o_out.field_kind == K_MSGEND)
        |-> o_out.record_index == 16'd0)
        else $error("header result with record index");

    a_idle_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("not empty after reset");

endmodule

bind dns_message_field_parser dmfp_port_checker u_chk (.*);

`default_nettype wire
